// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frequency stack RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define MFS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("mfs check failed");

// Expression must never be true outside reset.
`define MFS_NEVER(name, clk, rst_n, expr) \
  `MFS_ASSERT(name, clk, rst_n, !(expr))

`endif

// ===== rtl/mfs_pkg.sv =====
// Shared types and codes for the max frequency stack.
// No dependencies; used by mfs_cell, mfs_ctrl and max_frequency_stack.
package mfs_pkg;

  localparam int unsigned VALUE_W = 30;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_COMMIT
  } state_e;

  // control part of the sweep token moving down the cell chain
  typedef struct packed {
    logic valid;
    op_e  op;
    logic found;
  } tok_ctl_t;

  // broadcast update applied to all cells at the end of a word
  typedef struct packed {
    logic push_we;
    logic pop_shift;
  } cmt_t;

endpackage

// ===== rtl/mfs_cell.sv =====
// One stack cell: holds one entry and passes the sweep token to the cell below.
// Depends on mfs_pkg.
module mfs_cell #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX   = 0,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CNT_W-1:0]             fill_i,
  input  logic [CNT_W-1:0]             max_tag_i,
  input  mfs_pkg::tok_ctl_t            tok_ctl_i,
  input  logic [mfs_pkg::VALUE_W-1:0]  tok_key_i,
  input  logic [CNT_W-1:0]             tok_cnt_i,
  input  logic [IDX_W-1:0]             tok_pos_i,
  output mfs_pkg::tok_ctl_t            tok_ctl_o,
  output logic [mfs_pkg::VALUE_W-1:0]  tok_key_o,
  output logic [CNT_W-1:0]             tok_cnt_o,
  output logic [IDX_W-1:0]             tok_pos_o,
  input  mfs_pkg::cmt_t                cmt_i,
  input  logic [IDX_W-1:0]             cmt_pos_i,
  input  logic [mfs_pkg::VALUE_W-1:0]  cmt_value_i,
  input  logic [CNT_W-1:0]             cmt_tag_i,
  input  logic [mfs_pkg::VALUE_W-1:0]  up_value_i,
  input  logic [CNT_W-1:0]             up_tag_i,
  output logic [mfs_pkg::VALUE_W-1:0]  value_o,
  output logic [CNT_W-1:0]             tag_o
);

  localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);
  localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] POP_SAT = CNT_W'(2);

  logic [mfs_pkg::VALUE_W-1:0] value_q;
  logic [CNT_W-1:0]            tag_q;
  mfs_pkg::tok_ctl_t           ctl_d, ctl_q;
  logic [mfs_pkg::VALUE_W-1:0] key_d, key_q;
  logic [CNT_W-1:0]            cnt_d, cnt_q;
  logic [IDX_W-1:0]            pos_d, pos_q;
  logic                        occ, eq_val, eq_tag;

  always_comb begin
    occ    = MY_IDX < fill_i;
    eq_val = occ && (value_q == tok_key_i);
    eq_tag = occ && (tag_q == max_tag_i);
    ctl_d  = tok_ctl_i;
    key_d  = tok_key_i;
    cnt_d  = tok_cnt_i;
    pos_d  = tok_pos_i;
    if (tok_ctl_i.op == mfs_pkg::OP_PUSH) begin
      if (eq_val) cnt_d = tok_cnt_i + 1'b1;
    end else begin
      // saturating count of max-tag entries: two means at least one is left after the pop
      if (eq_tag && tok_cnt_i != POP_SAT) cnt_d = tok_cnt_i + 1'b1;
      if (occ && !tok_ctl_i.found) begin
        if (eq_tag) begin
          ctl_d.found = 1'b1;
          pos_d       = POS_IDX;
          key_d       = value_q;
        end else if (MY_NEXT == fill_i) begin
          pos_d = POS_IDX;
          key_d = value_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
    pos_q <= pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmt_i.push_we && MY_IDX == fill_i) begin
      value_q <= cmt_value_i;
      tag_q   <= cmt_tag_i;
    end else if (cmt_i.pop_shift && POS_IDX >= cmt_pos_i) begin
      value_q <= up_value_i;
      tag_q   <= up_tag_i;
    end
  end

  assign tok_ctl_o = ctl_q;
  assign tok_key_o = key_q;
  assign tok_cnt_o = cnt_q;
  assign tok_pos_o = pos_q;
  assign value_o   = value_q;
  assign tag_o     = tag_q;

endmodule

// ===== rtl/mfs_ctrl.sv =====
// Sequencer: handshakes, fill count, max tag, token injection and commit.
// Depends on mfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfs_ctrl #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [mfs_pkg::VALUE_W-1:0]  push_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mfs_pkg::VALUE_W-1:0]  pop_value_o,
  output logic [1:0]                   status_o,
  output mfs_pkg::tok_ctl_t            inj_ctl_o,
  output logic [mfs_pkg::VALUE_W-1:0]  inj_key_o,
  input  mfs_pkg::tok_ctl_t            ret_ctl_i,
  input  logic [mfs_pkg::VALUE_W-1:0]  ret_key_i,
  input  logic [CNT_W-1:0]             ret_cnt_i,
  input  logic [IDX_W-1:0]             ret_pos_i,
  output logic [CNT_W-1:0]             fill_o,
  output logic [CNT_W-1:0]             max_tag_o,
  output mfs_pkg::cmt_t                cmt_o,
  output logic [IDX_W-1:0]             cmt_pos_o,
  output logic [CNT_W-1:0]             cmt_tag_o
);

  localparam logic [CNT_W-1:0] FULL    = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] POP_SAT = CNT_W'(2);

  mfs_pkg::state_e             state_d, state_q;
  mfs_pkg::op_e                op_d, op_q;
  logic [mfs_pkg::VALUE_W-1:0] key_d, key_q;
  logic                        inj_d, inj_q;
  logic [mfs_pkg::VALUE_W-1:0] res_key_q;
  logic [CNT_W-1:0]            res_cnt_q;
  logic [IDX_W-1:0]            res_pos_q;
  logic [CNT_W-1:0]            fill_d, fill_q, max_d, max_q, new_tag;
  logic                        out_valid_d, out_valid_q;
  logic [mfs_pkg::VALUE_W-1:0] pop_value_d, pop_value_q;
  mfs_pkg::status_e            status_d, status_q;
  logic                        accept, out_free, commit_go;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != mfs_pkg::S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign new_tag    = res_cnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    inj_d       = 1'b0;
    fill_d      = fill_q;
    max_d       = max_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_value_d = pop_value_q;
    status_d    = status_q;
    commit_go   = 1'b0;
    cmt_o       = '0;
    unique case (state_q)
      mfs_pkg::S_IDLE: begin
        if (accept) begin
          op_d  = mfs_pkg::op_e'(operation_i);
          key_d = push_value_i;
          if (operation_i == mfs_pkg::OP_PUSH && fill_q == FULL) begin
            out_valid_d = 1'b1;
            pop_value_d = '0;
            status_d    = mfs_pkg::STAT_FULL;
          end else if (operation_i == mfs_pkg::OP_POP && fill_q == '0) begin
            out_valid_d = 1'b1;
            pop_value_d = '0;
            status_d    = mfs_pkg::STAT_EMPTY;
          end else begin
            inj_d   = 1'b1;
            state_d = mfs_pkg::S_SWEEP;
          end
        end
      end
      mfs_pkg::S_SWEEP: begin
        if (ret_ctl_i.valid) state_d = mfs_pkg::S_COMMIT;
      end
      mfs_pkg::S_COMMIT: begin
        if (out_free) begin
          commit_go   = 1'b1;
          state_d     = mfs_pkg::S_IDLE;
          out_valid_d = 1'b1;
          status_d    = mfs_pkg::STAT_OK;
          if (op_q == mfs_pkg::OP_PUSH) begin
            cmt_o.push_we = 1'b1;
            fill_d        = fill_q + 1'b1;
            pop_value_d   = '0;
            if (new_tag > max_q) max_d = new_tag;
          end else begin
            cmt_o.pop_shift = 1'b1;
            fill_d          = fill_q - 1'b1;
            pop_value_d     = res_key_q;
            if (res_cnt_q != POP_SAT && max_q != '0) max_d = max_q - 1'b1;
          end
        end
      end
      default: state_d = mfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfs_pkg::S_IDLE;
      inj_q       <= 1'b0;
      fill_q      <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      inj_q       <= inj_d;
      fill_q      <= fill_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    pop_value_q <= pop_value_d;
    status_q    <= status_d;
    if (state_q == mfs_pkg::S_SWEEP && ret_ctl_i.valid) begin
      res_key_q <= ret_key_i;
      res_cnt_q <= ret_cnt_i;
      res_pos_q <= ret_pos_i;
    end
  end

  assign inj_ctl_o = '{valid: inj_q, op: op_q, found: 1'b0};
  assign inj_key_o = key_q;
  assign fill_o    = fill_q;
  assign max_tag_o = max_q;
  assign cmt_pos_o = res_pos_q;
  assign cmt_tag_o = new_tag;

  assign out_valid_o = out_valid_q;
  assign pop_value_o = pop_value_q;
  assign status_o    = status_q;

  `MFS_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FULL)
  `MFS_ASSERT(a_ret_in_sweep, clk_i, rst_ni, ret_ctl_i.valid |-> state_q == mfs_pkg::S_SWEEP)
  `MFS_NEVER(a_push_full, clk_i, rst_ni, cmt_o.push_we && fill_q == FULL)
  `MFS_ASSERT(a_commit_idle, clk_i, rst_ni, commit_go |=> state_q == mfs_pkg::S_IDLE)

endmodule

// ===== rtl/max_frequency_stack.sv =====
// Max frequency stack: push counts equal entries, pop takes the topmost max-tag entry.
// A word that hits the store is answered after the token sweep down the cell chain,
// the result latch and the commit, which waits while the output is stalled; the next
// word is taken after the commit. A full push or empty pop answers in the next cycle.
// One word in flight at a time. Async active-low reset empties the store.
// Depends on mfs_pkg, mfs_cell, mfs_ctrl.
module max_frequency_stack #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [mfs_pkg::VALUE_W-1:0]  push_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mfs_pkg::VALUE_W-1:0]  pop_value_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  mfs_pkg::tok_ctl_t           tok_ctl [DEPTH+1];
  logic [mfs_pkg::VALUE_W-1:0] tok_key [DEPTH+1];
  logic [CNT_W-1:0]            tok_cnt [DEPTH+1];
  logic [IDX_W-1:0]            tok_pos [DEPTH+1];
  logic [mfs_pkg::VALUE_W-1:0] cell_value [DEPTH];
  logic [CNT_W-1:0]            cell_tag [DEPTH];

  logic [CNT_W-1:0] fill, max_tag, cmt_tag;
  logic [IDX_W-1:0] cmt_pos;
  mfs_pkg::cmt_t    cmt;

  assign tok_cnt[DEPTH] = '0;
  assign tok_pos[DEPTH] = '0;

  mfs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .inj_ctl_o    (tok_ctl[DEPTH]),
    .inj_key_o    (tok_key[DEPTH]),
    .ret_ctl_i    (tok_ctl[0]),
    .ret_key_i    (tok_key[0]),
    .ret_cnt_i    (tok_cnt[0]),
    .ret_pos_i    (tok_pos[0]),
    .fill_o       (fill),
    .max_tag_o    (max_tag),
    .cmt_o        (cmt),
    .cmt_pos_o    (cmt_pos),
    .cmt_tag_o    (cmt_tag)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [mfs_pkg::VALUE_W-1:0] up_value;
    logic [CNT_W-1:0]            up_tag;

    if (i == DEPTH - 1) begin : g_top
      assign up_value = cell_value[i];
      assign up_tag   = cell_tag[i];
    end else begin : g_mid
      assign up_value = cell_value[i+1];
      assign up_tag   = cell_tag[i+1];
    end

    mfs_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .fill_i      (fill),
      .max_tag_i   (max_tag),
      .tok_ctl_i   (tok_ctl[i+1]),
      .tok_key_i   (tok_key[i+1]),
      .tok_cnt_i   (tok_cnt[i+1]),
      .tok_pos_i   (tok_pos[i+1]),
      .tok_ctl_o   (tok_ctl[i]),
      .tok_key_o   (tok_key[i]),
      .tok_cnt_o   (tok_cnt[i]),
      .tok_pos_o   (tok_pos[i]),
      .cmt_i       (cmt),
      .cmt_pos_i   (cmt_pos),
      .cmt_value_i (tok_key[DEPTH]),
      .cmt_tag_i   (cmt_tag),
      .up_value_i  (up_value),
      .up_tag_i    (up_tag),
      .value_o     (cell_value[i]),
      .tag_o       (cell_tag[i])
    );
  end

endmodule
